// ===== sv/dfr_pkg.sv =====
package dfr_pkg;

	// Default store depth and reset values of the delimiter registers.
	localparam int unsigned STORE_BYTES_DEF = 32;
	localparam logic [7:0]  START_CHAR_RST  = 8'd42;
	localparam logic [7:0]  END_CHAR_RST    = 8'd35;

	// Request codes on req_type.
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_START_CHAR = 1'b0;
	localparam logic CFG_END_CHAR   = 1'b1;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_FRAME  = 2'd1,
		KIND_NONE   = 2'd2
	} kind_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic byte_step;
		logic none_result;
		logic read_start;
		logic read_beat;
	} dfr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic frame_ready;
		logic rd_last;
		logic out_free;
	} dfr_status_t;

endpackage

// ===== sv/dfr_ctrl.sv =====
module dfr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  dfr_pkg::dfr_status_t sts,
	output dfr_pkg::dfr_cmd_t    cmd
);
	import dfr_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = sts.out_free;
				if (in_valid && sts.out_free) begin
					if (req_type == REQ_BYTE) begin
						cmd.byte_step = 1'b1;
					end else if (sts.frame_ready) begin
						cmd.read_start = 1'b1;
						state_d        = ST_READ;
					end else begin
						cmd.none_result = 1'b1;
					end
				end
			end
			ST_READ: begin
				// One frame byte per beat while the output register is free.
				if (sts.out_free) begin
					cmd.read_beat = 1'b1;
					if (sts.rd_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/dfr_datapath.sv =====
module dfr_datapath #(
	parameter int unsigned STORE_BYTES = dfr_pkg::STORE_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_wdata,
	input  logic [7:0]           rx_byte,
	input  dfr_pkg::dfr_cmd_t    cmd,
	output dfr_pkg::dfr_status_t sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           kind,
	output logic [7:0]           frame_data,
	output logic                 last,
	output logic                 ready_flag,
	output logic                 overflow
);
	import dfr_pkg::*;

	localparam int unsigned      IDX_W    = $clog2(STORE_BYTES);
	localparam logic [IDX_W-1:0] FILL_MAX = IDX_W'(STORE_BYTES - 1);

	logic [7:0]       start_char_q;
	logic [7:0]       end_char_q;
	logic [IDX_W-1:0] fill_q;
	logic             in_frame_q;
	logic             frame_ready_q;
	logic [IDX_W-1:0] frame_len_q;
	logic [IDX_W-1:0] rd_idx_q;

	logic             out_valid_q;
	kind_t            kind_q;
	logic             last_q;
	logic             ready_flag_q;
	logic             overflow_q;
	logic [7:0]       rdata_q;

	logic [7:0]       mem [STORE_BYTES];

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic             is_full;
	logic             is_start;
	logic             is_end;
	logic             rd_last;

	// Decode of the received byte.
	assign is_full  = (fill_q == FILL_MAX);
	assign is_start = (rx_byte == start_char_q);
	assign is_end   = (rx_byte == end_char_q);
	assign rd_last  = ((rd_idx_q + IDX_W'(1)) == frame_len_q);

	// Store write: a start byte goes to entry zero, other kept bytes at the fill level.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_q;
		if (cmd.byte_step && !frame_ready_q && !is_full) begin
			if (is_start) begin
				mem_we    = 1'b1;
				mem_waddr = '0;
			end else if (is_end || in_frame_q) begin
				mem_we = 1'b1;
			end
		end
	end

	// Frame store, one write and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= rx_byte;
		end
		if (cmd.read_beat) begin
			rdata_q <= mem[rd_idx_q];
		end
	end

	// Delimiter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char_q <= START_CHAR_RST;
			end_char_q   <= END_CHAR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_CHAR: start_char_q <= cfg_wdata;
				CFG_END_CHAR:   end_char_q   <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	// Frame collection state and read pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			in_frame_q    <= 1'b0;
			frame_ready_q <= 1'b0;
			frame_len_q   <= '0;
			rd_idx_q      <= '0;
		end else begin
			if (cmd.byte_step && !frame_ready_q) begin
				if (is_full) begin
					fill_q     <= '0;
					in_frame_q <= 1'b0;
				end else if (is_start) begin
					fill_q     <= IDX_W'(1);
					in_frame_q <= 1'b1;
				end else if (is_end) begin
					frame_len_q   <= fill_q + IDX_W'(1);
					frame_ready_q <= 1'b1;
					fill_q        <= '0;
					in_frame_q    <= 1'b0;
				end else if (in_frame_q) begin
					fill_q <= fill_q + IDX_W'(1);
				end
			end
			if (cmd.read_start) begin
				rd_idx_q <= '0;
			end else if (cmd.read_beat) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
				if (rd_last) begin
					frame_ready_q <= 1'b0;
				end
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.byte_step || cmd.none_result || cmd.read_beat) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.byte_step) begin
			kind_q     <= KIND_STATUS;
			last_q     <= 1'b1;
			overflow_q <= !frame_ready_q && is_full;
			ready_flag_q <= frame_ready_q || (!is_full && !is_start && is_end);
		end else if (cmd.none_result) begin
			kind_q       <= KIND_NONE;
			last_q       <= 1'b1;
			overflow_q   <= 1'b0;
			ready_flag_q <= 1'b0;
		end else if (cmd.read_beat) begin
			kind_q       <= KIND_FRAME;
			last_q       <= rd_last;
			overflow_q   <= 1'b0;
			ready_flag_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign frame_data = (kind_q == KIND_FRAME) ? rdata_q : 8'd0;
	assign last       = last_q;
	assign ready_flag = ready_flag_q;
	assign overflow   = overflow_q;

	assign sts.frame_ready = frame_ready_q;
	assign sts.rd_last     = rd_last;
	assign sts.out_free    = !out_valid_q || out_ready;

endmodule

// ===== sv/delimited_frame_receiver_top.sv =====
// Delimited frame receiver: collects a frame that opens with start_char and closes with
// end_char (both kept) in an internal frame store, and streams it out on a read request.
// A received byte returns one status beat. A read of a waiting frame returns one beat per
// stored byte, paced by the single read port of the frame store and held while the output
// register is stalled; no input is taken until the last frame byte has been issued. A read
// with no frame waiting returns one beat. The frame store is not cleared at reset, since a
// read only covers entries the current frame has written. A frame holds at most STORE_BYTES-1
// bytes; the byte after that many drops the partial frame and reports overflow.
module delimited_frame_receiver_top #(
	parameter int unsigned STORE_BYTES = dfr_pkg::STORE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] frame_data,
	output logic       last,
	output logic       ready_flag,
	output logic       overflow
);
	import dfr_pkg::*;

	dfr_cmd_t    cmd;
	dfr_status_t sts;

	// Sequencing of request acceptance and frame streaming.
	dfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Frame store, collection state and output register.
	dfr_datapath #(
		.STORE_BYTES (STORE_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.rx_byte    (rx_byte),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.frame_data (frame_data),
		.last       (last),
		.ready_flag (ready_flag),
		.overflow   (overflow)
	);

endmodule

// ===== sv/dfr_checker.sv =====
module dfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] frame_data,
	input logic       last,
	input logic       ready_flag,
	input logic       overflow
);
	import dfr_pkg::*;

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({kind, frame_data, last, ready_flag, overflow}))
		else $error("stalled result beat changed");

	// Frame bytes never carry ready or overflow.
	a_frame_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FRAME |-> !ready_flag && !overflow)
		else $error("frame byte with status flags");

	// Status and no-frame beats are single, data-free results.
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_STATUS || kind == KIND_NONE) |-> last && frame_data == 8'd0)
		else $error("status beat malformed");

	// A no-frame result never reports a waiting frame or overflow.
	a_none_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_NONE |-> !ready_flag && !overflow)
		else $error("no-frame beat with flags");

	// While a frame byte other than the last one is on the output, no new request is taken.
	a_stream_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FRAME && !last |-> !in_ready)
		else $error("request taken during frame stream");

endmodule

bind delimited_frame_receiver_top dfr_checker u_dfr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.kind       (kind),
	.frame_data (frame_data),
	.last       (last),
	.ready_flag (ready_flag),
	.overflow   (overflow)
);

// ===== bench/delimited_frame_receiver_checker.sv =====
`timescale 1ns / 1ps
module delimited_frame_receiver_checker #(
	parameter int unsigned STORE_BYTES = dfr_pkg::STORE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [1:0] kind,
	input  logic [7:0] frame_data,
	input  logic       last,
	input  logic       ready_flag,
	input  logic       overflow,
	output int         fail_count,
	output int         results_owed,
	output int         beats_checked,
	output int         frames_read,
	output int         overflow_drops
);
	import dfr_pkg::*;

	// One result beat as the receiver should produce it.
	typedef struct {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
		logic       ready;
		logic       ovf;
	} rx_result_t;

	rx_result_t owed_beats[$];

	// Shadow copy of the delimiter registers and of the frame collector.
	logic [7:0]  open_char;
	logic [7:0]  close_char;
	logic [7:0]  frame_mem [STORE_BYTES];
	int unsigned held;
	logic        collecting;
	logic        frame_waiting;
	int unsigned frame_len;

	task automatic owe(kind_t k, logic [7:0] d, logic l, logic r, logic o);
		rx_result_t res;
		res.kind  = k;
		res.data  = d;
		res.last  = l;
		res.ready = r;
		res.ovf   = o;
		owed_beats.push_back(res);
	endtask

	// Advance the shadow collector by one request beat and queue the beats it yields.
	task automatic collect_request(logic req, logic [7:0] b);
		int unsigned n;
		if (req == REQ_READ) begin
			if (!frame_waiting) begin
				owe(KIND_NONE, 8'h00, 1'b1, 1'b0, 1'b0);
			end else begin
				n = (frame_len > STORE_BYTES - 1) ? STORE_BYTES - 1 : frame_len;
				if (n == 0)
					owe(KIND_NONE, 8'h00, 1'b1, 1'b0, 1'b0);
				for (int i = 0; i < n; i++)
					owe(KIND_FRAME, frame_mem[i], (i + 1 == n), 1'b0, 1'b0);
				frame_waiting = 1'b0;
			end
		end else if (frame_waiting) begin
			// A finished frame blocks the collector; the byte is lost.
			owe(KIND_STATUS, 8'h00, 1'b1, 1'b1, 1'b0);
		end else if (held >= STORE_BYTES - 1) begin
			// Store full: this byte and the partial frame are dropped.
			held = 0;
			collecting = 1'b0;
			owe(KIND_STATUS, 8'h00, 1'b1, 1'b0, 1'b1);
		end else begin
			// The start test wins over the end test when both delimiters match.
			if (b == open_char) begin
				frame_mem[0] = b;
				held = 1;
				collecting = 1'b1;
			end else if (b == close_char) begin
				frame_mem[held] = b;
				frame_len = held + 1;
				frame_waiting = 1'b1;
				held = 0;
				collecting = 1'b0;
			end else if (collecting) begin
				frame_mem[held] = b;
				held++;
			end
			owe(KIND_STATUS, 8'h00, 1'b1, frame_waiting, 1'b0);
		end
	endtask

	// Keep the log bounded when the block is badly off.
	function automatic void report(string what, logic [7:0] want, logic [7:0] got);
		if (fail_count < 25)
			$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
	endfunction

	// Compare one accepted result beat with the oldest owed beat.
	task automatic check_beat();
		rx_result_t want;
		logic bad;
		beats_checked++;
		if (owed_beats.size() == 0) begin
			report("result beat with nothing owed, kind", 8'hxx, 8'(kind));
			fail_count++;
			return;
		end
		want = owed_beats.pop_front();
		bad = 1'b0;
		if (kind !== want.kind) begin
			report("kind", 8'(want.kind), 8'(kind));
			bad = 1'b1;
		end
		if (frame_data !== want.data) begin
			report("frame_data", want.data, frame_data);
			bad = 1'b1;
		end
		if (last !== want.last) begin
			report("last", 8'(want.last), 8'(last));
			bad = 1'b1;
		end
		if (ready_flag !== want.ready) begin
			report("ready_flag", 8'(want.ready), 8'(ready_flag));
			bad = 1'b1;
		end
		if (overflow !== want.ovf) begin
			report("overflow", 8'(want.ovf), 8'(overflow));
			bad = 1'b1;
		end
		if (bad)
			fail_count++;
		if (want.kind == KIND_FRAME && want.last)
			frames_read++;
		if (want.ovf)
			overflow_drops++;
	endtask

	// Watch the configuration port and both channels on every rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_char      = START_CHAR_RST;
			close_char     = END_CHAR_RST;
			held           = 0;
			collecting     = 1'b0;
			frame_waiting  = 1'b0;
			frame_len      = 0;
			owed_beats.delete();
			fail_count     = 0;
			results_owed   = 0;
			beats_checked  = 0;
			frames_read    = 0;
			overflow_drops = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_START_CHAR)
					open_char = cfg_wdata;
				else if (cfg_index == CFG_END_CHAR)
					close_char = cfg_wdata;
			end
			if (in_valid && in_ready)
				collect_request(req_type, rx_byte);
			if (out_valid && out_ready)
				check_beat();
			results_owed = owed_beats.size();
		end
	end

endmodule

// ===== bench/tb_delimited_frame_receiver_top.sv =====
`timescale 1ns / 1ps
module tb_delimited_frame_receiver_top;
	import dfr_pkg::*;

	localparam int unsigned STORE_BYTES = STORE_BYTES_DEF;
	localparam int IDLE_LIMIT      = 2000;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 60;

	typedef enum int {
		DRAIN_FREE,
		DRAIN_RANDOM,
		DRAIN_PATTERN
	} drain_mode_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       cfg_we     = 1'b0;
	logic       cfg_index  = CFG_START_CHAR;
	logic [7:0] cfg_wdata  = 8'h00;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic       req_type   = REQ_BYTE;
	logic [7:0] rx_byte    = 8'h00;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic [1:0] kind;
	logic [7:0] frame_data;
	logic       last;
	logic       ready_flag;
	logic       overflow;

	int fail_count;
	int results_owed;
	int beats_checked;
	int frames_read;
	int overflow_drops;

	// Delimiters currently programmed, used to shape the byte stream.
	logic [7:0] open_char  = START_CHAR_RST;
	logic [7:0] close_char = END_CHAR_RST;

	int          items_sent  = 0;
	int          burst_left  = 0;
	int          idle_cycles = 0;
	drain_mode_t drain_mode  = DRAIN_FREE;
	int          drain_span  = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	delimited_frame_receiver_top #(
		.STORE_BYTES(STORE_BYTES)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.frame_data (frame_data),
		.last       (last),
		.ready_flag (ready_flag),
		.overflow   (overflow)
	);

	delimited_frame_receiver_checker #(
		.STORE_BYTES(STORE_BYTES)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.frame_data     (frame_data),
		.last           (last),
		.ready_flag     (ready_flag),
		.overflow       (overflow),
		.fail_count     (fail_count),
		.results_owed   (results_owed),
		.beats_checked  (beats_checked),
		.frames_read    (frames_read),
		.overflow_drops (overflow_drops)
	);

	// Result back-pressure: spans of free flow, random stalls and a fixed stall pattern.
	always @(posedge clk) begin
		if (drain_span == 0) begin
			drain_mode <= drain_mode_t'($urandom_range(0, 2));
			drain_span <= $urandom_range(20, 150);
		end else begin
			drain_span <= drain_span - 1;
		end
		case (drain_mode)
			DRAIN_FREE:   out_ready <= 1'b1;
			DRAIN_RANDOM: out_ready <= ($urandom_range(0, 1) == 1);
			default:      out_ready <= ((drain_span % 8) < 3);
		endcase
	end

	// Watchdog: too long without any beat on either channel ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Offer one request beat and hold it until accepted; bursts may end with a random gap.
	task automatic send_beat(logic req, logic [7:0] b);
		int gap;
		in_valid <= 1'b1;
		req_type <= req;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop sending and wait until every owed result beat has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Program both delimiters while the block is idle.
	task automatic set_delimiters(logic [7:0] s, logic [7:0] e);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_START_CHAR;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_index <= CFG_END_CHAR;
		cfg_wdata <= e;
		@(posedge clk);
		cfg_we     <= 1'b0;
		open_char  = s;
		close_char = e;
	endtask

	// A payload byte that is neither delimiter.
	function automatic logic [7:0] filler();
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == open_char || v == close_char);
		return v;
	endfunction

	// A complete frame; some bodies are long enough to reach or overrun the store.
	task automatic send_frame();
		int body;
		body = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 8)
			: $urandom_range(STORE_BYTES - 5, STORE_BYTES);
		send_beat(REQ_BYTE, open_char);
		repeat (body) send_beat(REQ_BYTE, filler());
		send_beat(REQ_BYTE, close_char);
		if ($urandom_range(0, 3) == 0)
			send_beat(REQ_BYTE, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 5) != 0)
			send_beat(REQ_READ, 8'($urandom_range(0, 255)));
	endtask

	// A frame cut by a restart or by an early read request.
	task automatic send_broken_frame();
		send_beat(REQ_BYTE, open_char);
		repeat ($urandom_range(0, 4)) send_beat(REQ_BYTE, filler());
		send_beat($urandom_range(0, 1) ? REQ_READ : REQ_BYTE, open_char);
		repeat ($urandom_range(0, 4)) send_beat(REQ_BYTE, filler());
		send_beat(REQ_BYTE, close_char);
		send_beat(REQ_READ, 8'($urandom_range(0, 255)));
	endtask

	// Loose beats with delimiters and reads mixed in.
	task automatic send_noise();
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 5))
				0:       send_beat(REQ_READ, 8'($urandom_range(0, 255)));
				1:       send_beat(REQ_BYTE, open_char);
				2:       send_beat(REQ_BYTE, close_char);
				default: send_beat(REQ_BYTE, 8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	initial begin
		int target;
		logic [7:0] s;
		logic [7:0] e;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats with the reset delimiters.
		send_beat(REQ_READ, 8'hFF);         // read with nothing waiting
		send_beat(REQ_BYTE, 8'h00);         // dropped outside a frame
		send_beat(REQ_BYTE, 8'hFF);         // dropped outside a frame
		send_beat(REQ_BYTE, END_CHAR_RST);  // end with no start: one-byte frame
		send_beat(REQ_BYTE, START_CHAR_RST); // ignored while a frame waits
		send_beat(REQ_READ, 8'h00);
		send_beat(REQ_READ, 8'h00);         // frame already taken
		send_beat(REQ_BYTE, START_CHAR_RST);
		send_beat(REQ_BYTE, 8'h00);         // zero byte is stored
		send_beat(REQ_BYTE, 8'hFF);
		send_beat(REQ_READ, 8'h5A);         // partial frame must survive this
		send_beat(REQ_BYTE, START_CHAR_RST); // restart
		send_beat(REQ_BYTE, 8'h5A);
		send_beat(REQ_BYTE, END_CHAR_RST);
		send_beat(REQ_BYTE, 8'hA5);
		send_beat(REQ_READ, 8'hA5);

		// Equal delimiters: the start meaning takes priority.
		set_delimiters(8'h55, 8'h55);
		send_beat(REQ_BYTE, 8'h55);
		send_beat(REQ_BYTE, 8'hAA);
		send_beat(REQ_BYTE, 8'h55);
		send_beat(REQ_READ, 8'h00);

		// Random traffic under a series of delimiter settings, extremes first.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin s = START_CHAR_RST; e = END_CHAR_RST; end
				1: begin s = 8'h00; e = 8'hFF; end
				2: begin s = 8'hFF; e = 8'h00; end
				3: begin s = 8'h7E; e = 8'h7E; end
				default: begin
					s = 8'($urandom_range(0, 255));
					e = 8'($urandom_range(0, 255));
				end
			endcase
			set_delimiters(s, e);
			target = items_sent + ITEMS_PER_PHASE;
			while (items_sent < target) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: send_frame();
					6, 7:             send_noise();
					8:                send_broken_frame();
					default:          send_beat(REQ_READ, 8'($urandom_range(0, 255)));
				endcase
				if ($urandom_range(0, 19) == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		$display("Sent %0d request beats under %0d delimiter settings; %0d result beats checked.",
			items_sent, PHASES + 2, beats_checked);
		$display("Frames read out: %0d; full-store discards: %0d.", frames_read, overflow_drops);
		if (fail_count == 0 && results_owed == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== delimited_frame_receiver_top.f =====
sv/dfr_pkg.sv
sv/dfr_ctrl.sv
sv/dfr_datapath.sv
sv/delimited_frame_receiver_top.sv
sv/dfr_checker.sv
bench/delimited_frame_receiver_checker.sv
bench/tb_delimited_frame_receiver_top.sv
